// ----- src/hsv_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package hsv_pkg;

	localparam int unsigned HSV_HUE_FRAC_BITS = 4;

	localparam int unsigned HUE_W        = 16;
	localparam int unsigned CH_W         = 8;

	localparam int unsigned SECTOR_DEG   = 60;
	localparam int unsigned SECTOR_COUNT = 6;
	localparam int unsigned FULL_SCALE   = 255;

	// hue mod 360 degrees: floor(h * MOD_RECIP / 2^MOD_SHIFT) is exact or one low
	localparam int unsigned HUE_MOD      = SECTOR_DEG * SECTOR_COUNT;
	localparam int unsigned MOD_SHIFT    = 25;
	localparam int unsigned MOD_RECIP    = (1 << MOD_SHIFT) / HUE_MOD;
	localparam int unsigned MOD_RECIP_W  = $clog2(MOD_RECIP + 1);
	localparam int unsigned HUE_Q_W      = $clog2(((1 << HUE_W) - 1) / HUE_MOD + 1);
	localparam int unsigned HUE_M_W      = $clog2(HUE_MOD);

	// channel scaling: divide by 255 * 60 after the fraction bits are shifted out
	localparam int unsigned SCALE_DEN    = FULL_SCALE * SECTOR_DEG;
	localparam int unsigned SCALE_SHIFT  = 24;
	localparam int unsigned SCALE_RECIP  = (1 << SCALE_SHIFT) / SCALE_DEN;
	localparam int unsigned SCALE_RCP_W  = $clog2(SCALE_RECIP + 1);
	localparam int unsigned SCALED_W     = $clog2(FULL_SCALE * SCALE_DEN + 1);

	typedef enum logic [2:0] {
		SEC_R_Y = 3'd0,
		SEC_Y_G = 3'd1,
		SEC_G_C = 3'd2,
		SEC_C_B = 3'd3,
		SEC_B_M = 3'd4,
		SEC_M_R = 3'd5
	} hsv_sector_t;

	typedef struct packed {
		logic        valid;
		hsv_sector_t sector;
	} hsv_ctl_t;

endpackage

`default_nettype wire

// ----- src/hsv_sector.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hsv_sector #(
	parameter int unsigned HUE_FRAC_BITS = hsv_pkg::HSV_HUE_FRAC_BITS
) (
	input  wire logic                                             clk,
	input  wire logic                                             arst_n,
	input  wire logic                                             in_valid,
	input  wire logic [hsv_pkg::HUE_W-1:0]                        hue,
	input  wire logic [hsv_pkg::CH_W-1:0]                         saturation,
	input  wire logic [hsv_pkg::CH_W-1:0]                         brightness,
	output hsv_pkg::hsv_ctl_t                                     ctl,
	output logic [$clog2(hsv_pkg::SECTOR_DEG << HUE_FRAC_BITS)-1:0] rem,
	output logic [hsv_pkg::CH_W-1:0]                              sat,
	output logic [hsv_pkg::CH_W-1:0]                              val
);
	import hsv_pkg::*;

	localparam int unsigned W       = SECTOR_DEG << HUE_FRAC_BITS;
	localparam int unsigned RW      = $clog2(W);
	localparam int unsigned LW      = (HUE_FRAC_BITS > 0) ? HUE_FRAC_BITS : 1;
	localparam logic [LW-1:0] LO_MASK = LW'((1 << HUE_FRAC_BITS) - 1);
	localparam int unsigned PW      = HUE_W + MOD_RECIP_W;
	localparam int unsigned MW      = HUE_W + 1;

	logic [HUE_W-1:0]   h_c;
	logic [PW-1:0]      prod_c;
	logic [MW-1:0]      m_full_c;
	logic [MW-1:0]      m_corr_c;
	logic [HUE_M_W-1:0] base_c;
	hsv_sector_t        sector_c;
	logic [5:0]         rem_hi_c;

	logic               vld_s1, vld_s2, vld_s3;
	logic [HUE_W-1:0]   h_s1;
	logic [HUE_Q_W-1:0] qe_s1;
	logic [LW-1:0]      lo_s1, lo_s2;
	logic [CH_W-1:0]    sat_s1, sat_s2, sat_s3;
	logic [CH_W-1:0]    val_s1, val_s2, val_s3;
	logic [HUE_M_W-1:0] m_s2;
	hsv_sector_t        sector_s3;
	logic [RW-1:0]      rem_s3;

	always_comb begin
		h_c      = hue >> HUE_FRAC_BITS;
		prod_c   = PW'(h_c) * PW'(MOD_RECIP);
		m_full_c = MW'(h_s1) - MW'(qe_s1) * MW'(HUE_MOD);
		m_corr_c = (m_full_c >= MW'(HUE_MOD)) ? m_full_c - MW'(HUE_MOD) : m_full_c;
	end

	always_comb begin
		if (m_s2 >= HUE_M_W'(5 * SECTOR_DEG)) begin
			sector_c = SEC_M_R;
			base_c   = HUE_M_W'(5 * SECTOR_DEG);
		end else if (m_s2 >= HUE_M_W'(4 * SECTOR_DEG)) begin
			sector_c = SEC_B_M;
			base_c   = HUE_M_W'(4 * SECTOR_DEG);
		end else if (m_s2 >= HUE_M_W'(3 * SECTOR_DEG)) begin
			sector_c = SEC_C_B;
			base_c   = HUE_M_W'(3 * SECTOR_DEG);
		end else if (m_s2 >= HUE_M_W'(2 * SECTOR_DEG)) begin
			sector_c = SEC_G_C;
			base_c   = HUE_M_W'(2 * SECTOR_DEG);
		end else if (m_s2 >= HUE_M_W'(SECTOR_DEG)) begin
			sector_c = SEC_Y_G;
			base_c   = HUE_M_W'(SECTOR_DEG);
		end else begin
			sector_c = SEC_R_Y;
			base_c   = '0;
		end
		rem_hi_c = 6'(m_s2 - base_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		h_s1      <= h_c;
		qe_s1     <= prod_c[MOD_SHIFT +: HUE_Q_W];
		lo_s1     <= hue[LW-1:0] & LO_MASK;
		sat_s1    <= saturation;
		val_s1    <= brightness;

		m_s2      <= HUE_M_W'(m_corr_c);
		lo_s2     <= lo_s1;
		sat_s2    <= sat_s1;
		val_s2    <= val_s1;

		sector_s3 <= sector_c;
		rem_s3    <= (RW'(rem_hi_c) << HUE_FRAC_BITS) | RW'(lo_s2);
		sat_s3    <= sat_s2;
		val_s3    <= val_s2;
	end

	assign ctl = '{valid: vld_s3, sector: sector_s3};
	assign rem = rem_s3;
	assign sat = sat_s3;
	assign val = val_s3;

	a_mod_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> (m_s2 < HUE_M_W'(HUE_MOD)))
		else $error("hue reduction out of range");

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 |-> (rem_s3 < RW'(W)))
		else $error("sector remainder out of range");

	a_valid_chain: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid |-> ##3 vld_s3)
		else $error("transaction lost in hue stages");

endmodule

`default_nettype wire

// ----- src/hsv_chan.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hsv_chan #(
	parameter int unsigned HUE_FRAC_BITS = hsv_pkg::HSV_HUE_FRAC_BITS
) (
	input  wire logic                                                 clk,
	input  wire logic [$clog2((hsv_pkg::SECTOR_DEG << HUE_FRAC_BITS) + 1)-1:0] k,
	input  wire logic [hsv_pkg::CH_W-1:0]                             sat,
	input  wire logic [hsv_pkg::CH_W-1:0]                             val,
	output logic      [hsv_pkg::CH_W-1:0]                             chan
);
	import hsv_pkg::*;

	localparam int unsigned W   = SECTOR_DEG << HUE_FRAC_BITS;
	localparam int unsigned KW  = $clog2(W + 1);
	localparam int unsigned DEN = FULL_SCALE * W;
	localparam int unsigned DW  = $clog2(DEN + 1);
	localparam int unsigned XW  = DW + CH_W;
	localparam int unsigned YW  = SCALED_W;
	localparam int unsigned PW  = YW + SCALE_RCP_W;

	logic [KW+CH_W-1:0] ks_c;
	logic [XW-1:0]      x_c;
	logic [PW-1:0]      p_c;
	logic [YW-1:0]      back_c;
	logic [YW-1:0]      rr_c;

	logic [DW-1:0]      num_s4;
	logic [CH_W-1:0]    val_s4;
	logic [YW-1:0]      y_s5, y_s6;
	logic [CH_W-1:0]    qe_s6;
	logic [CH_W-1:0]    chan_s7;

	always_comb begin
		ks_c   = (KW+CH_W)'(k) * (KW+CH_W)'(sat);
		x_c    = XW'(val_s4) * XW'(num_s4);
		p_c    = PW'(y_s5) * PW'(SCALE_RECIP);
		back_c = YW'(qe_s6) * YW'(SCALE_DEN);
		rr_c   = y_s6 - back_c;
	end

	always_ff @(posedge clk) begin
		num_s4  <= DW'(DEN) - DW'(ks_c);
		val_s4  <= val;
		y_s5    <= YW'(x_c >> HUE_FRAC_BITS);
		y_s6    <= y_s5;
		qe_s6   <= p_c[SCALE_SHIFT +: CH_W];
		chan_s7 <= (rr_c >= YW'(SCALE_DEN)) ? qe_s6 + CH_W'(1) : qe_s6;
	end

	assign chan = chan_s7;

endmodule

`default_nettype wire

// ----- src/hsv_to_rgb_converter.sv -----
`timescale 1ns / 1ps
`default_nettype none

// HSV to RGB pixel converter. A pixel is taken on every clock in which start is
// high; busy never rises, so pixels may stream back to back. Each result shows up
// on red, green and blue with a one-cycle done pulse, and must be taken in that
// cycle: the receiver cannot stall the block. Of the pipeline stages, three
// reduce the hue to a sector and remainder, four scale the three computed
// channels in parallel lanes, and one orders the channels by sector into the
// output register.
module hsv_to_rgb_converter #(
	parameter int unsigned HUE_FRAC_BITS = hsv_pkg::HSV_HUE_FRAC_BITS
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic [hsv_pkg::HUE_W-1:0]   hue,
	input  wire logic [hsv_pkg::CH_W-1:0]    saturation,
	input  wire logic [hsv_pkg::CH_W-1:0]    brightness,
	output logic                             done,
	output logic      [hsv_pkg::CH_W-1:0]    red,
	output logic      [hsv_pkg::CH_W-1:0]    green,
	output logic      [hsv_pkg::CH_W-1:0]    blue
);
	import hsv_pkg::*;

	localparam int unsigned W  = SECTOR_DEG << HUE_FRAC_BITS;
	localparam int unsigned RW = $clog2(W);
	localparam int unsigned KW = $clog2(W + 1);

	hsv_ctl_t        ctl_s3;
	logic [RW-1:0]   rem_s3;
	logic [CH_W-1:0] sat_s3;
	logic [CH_W-1:0] val_s3;

	logic [KW-1:0]   k_q_c, k_t_c, k_p_c;
	logic [CH_W-1:0] cq_s7, ct_s7, cp_s7;

	hsv_ctl_t        ctl_s4, ctl_s5, ctl_s6, ctl_s7;
	logic [CH_W-1:0] val_s4, val_s5, val_s6, val_s7;

	logic [CH_W-1:0] r_c, g_c, b_c;
	logic            done_q;
	logic [CH_W-1:0] red_q, green_q, blue_q;

	assign busy = 1'b0;

	hsv_sector #(
		.HUE_FRAC_BITS(HUE_FRAC_BITS)
	) u_sector (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (start && !busy),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness),
		.ctl        (ctl_s3),
		.rem        (rem_s3),
		.sat        (sat_s3),
		.val        (val_s3)
	);

	// q uses f, t uses 1-f, p uses the full sector width
	always_comb begin
		k_q_c = KW'(rem_s3);
		k_t_c = KW'(W) - KW'(rem_s3);
		k_p_c = KW'(W);
	end

	hsv_chan #(.HUE_FRAC_BITS(HUE_FRAC_BITS)) u_chan_q (
		.clk(clk), .k(k_q_c), .sat(sat_s3), .val(val_s3), .chan(cq_s7)
	);

	hsv_chan #(.HUE_FRAC_BITS(HUE_FRAC_BITS)) u_chan_t (
		.clk(clk), .k(k_t_c), .sat(sat_s3), .val(val_s3), .chan(ct_s7)
	);

	hsv_chan #(.HUE_FRAC_BITS(HUE_FRAC_BITS)) u_chan_p (
		.clk(clk), .k(k_p_c), .sat(sat_s3), .val(val_s3), .chan(cp_s7)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6 <= '0;
			ctl_s7 <= '0;
			done_q <= 1'b0;
		end else begin
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
			ctl_s6 <= ctl_s5;
			ctl_s7 <= ctl_s6;
			done_q <= ctl_s7.valid;
		end
	end

	always_ff @(posedge clk) begin
		val_s4        <= val_s3;
		val_s5        <= val_s4;
		val_s6        <= val_s5;
		val_s7        <= val_s6;
		red_q         <= r_c;
		green_q       <= g_c;
		blue_q        <= b_c;
	end

	always_comb begin
		case (ctl_s7.sector)
			SEC_Y_G: begin
				r_c = cq_s7;  g_c = val_s7; b_c = cp_s7;
			end
			SEC_G_C: begin
				r_c = cp_s7;  g_c = val_s7; b_c = ct_s7;
			end
			SEC_C_B: begin
				r_c = cp_s7;  g_c = cq_s7;  b_c = val_s7;
			end
			SEC_B_M: begin
				r_c = ct_s7;  g_c = cp_s7;  b_c = val_s7;
			end
			SEC_M_R: begin
				r_c = val_s7; g_c = cp_s7;  b_c = cq_s7;
			end
			default: begin
				r_c = val_s7; g_c = ct_s7;  b_c = cp_s7;
			end
		endcase
	end

	assign done  = done_q;
	assign red   = red_q;
	assign green = green_q;
	assign blue  = blue_q;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##8 done)
		else $error("transaction did not complete in 8 cycles");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 8))
		else $error("done without a matching transaction");

	a_chan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((red <= $past(brightness, 8)) && (green <= $past(brightness, 8)) &&
			(blue <= $past(brightness, 8))))
		else $error("channel exceeds brightness");

	a_chan_peak: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((red == $past(brightness, 8)) || (green == $past(brightness, 8)) ||
			(blue == $past(brightness, 8))))
		else $error("no channel carries the brightness");

endmodule

`default_nettype wire

// ----- tb/sv/tb_hsv_to_rgb_converter.sv -----
`timescale 1ns / 1ps

module tb_hsv_to_rgb_converter;
	import hsv_pkg::*;

	localparam int unsigned FRAC_BITS = HSV_HUE_FRAC_BITS;
	localparam int DIRECTED_N = 22;
	localparam int RANDOM_N = 1430;
	localparam int CALM_TAIL = 200;
	localparam int PIPE_DEPTH = 8;
	localparam int WATCHDOG_LIMIT = 1000;

	typedef struct packed {
		logic [CH_W-1:0] r;
		logic [CH_W-1:0] g;
		logic [CH_W-1:0] b;
	} rgb_t;

	typedef struct packed {
		logic [HUE_W-1:0] h;
		logic [CH_W-1:0]  s;
		logic [CH_W-1:0]  v;
		logic             known;
		rgb_t             rgb;
	} pixel_row_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic [HUE_W-1:0] hue;
	logic [CH_W-1:0]  saturation;
	logic [CH_W-1:0]  brightness;
	logic             done;
	logic [CH_W-1:0]  red;
	logic [CH_W-1:0]  green;
	logic [CH_W-1:0]  blue;

	// typed-in expectation riding along with the transaction on start
	logic stim_known;
	rgb_t stim_rgb;

	rgb_t rgb_expected_q[$];
	rgb_t rgb_head;
	int   fail_count = 0;
	int   stall_cycles = 0;

	// rows marked known carry the answer; the rest go through the predictor
	pixel_row_t pixel_rows [DIRECTED_N] = '{
		'{16'd0,     8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd0}},
		'{16'd1920,  8'd255, 8'd255, 1'b1, '{8'd0,   8'd255, 8'd0}},
		'{16'd3840,  8'd255, 8'd255, 1'b1, '{8'd0,   8'd0,   8'd255}},
		'{16'd5760,  8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd0}},
		'{16'd0,     8'd0,   8'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
		'{16'd12345, 8'd0,   8'd200, 1'b1, '{8'd200, 8'd200, 8'd200}},
		'{16'd65535, 8'd255, 8'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
		'{16'd65535, 8'd0,   8'd255, 1'b1, '{8'd255, 8'd255, 8'd255}},
		'{16'd960,   8'd255, 8'd255, 1'b1, '{8'd255, 8'd255, 8'd0}},
		'{16'd2880,  8'd255, 8'd255, 1'b1, '{8'd0,   8'd255, 8'd255}},
		'{16'd4800,  8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd255}},
		'{16'd65280, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd255, 8'd0}},
		'{16'd65535, 8'd255, 8'd255, 1'b0, '0},
		'{16'd959,   8'd255, 8'd255, 1'b0, '0},
		'{16'd480,   8'd128, 8'd200, 1'b0, '0},
		'{16'd1440,  8'd255, 8'd128, 1'b0, '0},
		'{16'd2400,  8'd1,   8'd254, 1'b0, '0},
		'{16'd3360,  8'd254, 8'd1,   1'b0, '0},
		'{16'd4320,  8'd170, 8'd85,  1'b0, '0},
		'{16'd5280,  8'd85,  8'd170, 1'b0, '0},
		'{16'd5759,  8'd255, 8'd255, 1'b0, '0},
		'{16'd11520, 8'd200, 8'd100, 1'b0, '0}
	};

	hsv_to_rgb_converter dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness),
		.done       (done),
		.red        (red),
		.green      (green),
		.blue       (blue)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic rgb_t hsv_expected(input logic [HUE_W-1:0] h, input logic [CH_W-1:0] s,
			input logic [CH_W-1:0] v);
		longint unsigned wd;
		longint unsigned den;
		longint unsigned rem;
		longint unsigned vv;
		longint unsigned cp;
		longint unsigned cq;
		longint unsigned ct;
		hsv_sector_t     sec;
		rgb_t            pix;
		wd = longint'(SECTOR_DEG) << FRAC_BITS;
		sec = hsv_sector_t'(3'((h / wd) % SECTOR_COUNT));
		rem = h % wd;
		den = FULL_SCALE * wd;
		vv = v;
		cp = vv * (FULL_SCALE - s) / FULL_SCALE;
		cq = vv * (den - rem * s) / den;
		ct = vv * (den - (wd - rem) * s) / den;
		case (sec)
			SEC_Y_G: pix = '{cq[7:0], vv[7:0], cp[7:0]};
			SEC_G_C: pix = '{cp[7:0], vv[7:0], ct[7:0]};
			SEC_C_B: pix = '{cp[7:0], cq[7:0], vv[7:0]};
			SEC_B_M: pix = '{ct[7:0], cp[7:0], vv[7:0]};
			SEC_M_R: pix = '{vv[7:0], cp[7:0], cq[7:0]};
			default: pix = '{vv[7:0], ct[7:0], cp[7:0]};
		endcase
		return pix;
	endfunction

	function automatic logic [HUE_W-1:0] pick_hue();
		int unsigned k;
		int unsigned offs [4] = '{0, 1, 958, 959};
		case ($urandom_range(0, 3))
			0: begin
				k = $urandom_range(0, 67);
				return HUE_W'(k * 960 + offs[$urandom_range(0, 3)]);
			end
			1: return HUE_W'($urandom_range(0, 5759));
			default: return HUE_W'($urandom);
		endcase
	endfunction

	function automatic logic [CH_W-1:0] pick_level();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return CH_W'($urandom);
		endcase
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (rgb_expected_q.size() == 0) begin
					$error("unexpected transaction: red %0d green %0d blue %0d", red, green, blue);
					fail_count++;
				end else begin
					rgb_head = rgb_expected_q.pop_front();
					if (red !== rgb_head.r) begin
						$error("red: expected %0d, got %0d", rgb_head.r, red);
						fail_count++;
					end
					if (green !== rgb_head.g) begin
						$error("green: expected %0d, got %0d", rgb_head.g, green);
						fail_count++;
					end
					if (blue !== rgb_head.b) begin
						$error("blue: expected %0d, got %0d", rgb_head.b, blue);
						fail_count++;
					end
				end
			end
			if (start && !busy)
				rgb_expected_q.push_back(stim_known ? stim_rgb
					: hsv_expected(hue, saturation, brightness));
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic send_pixel(input logic [HUE_W-1:0] h, input logic [CH_W-1:0] s,
			input logic [CH_W-1:0] v, input logic known, input rgb_t rgb, input bit allow_idle);
		if (allow_idle && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			hue <= HUE_W'($urandom);
			saturation <= CH_W'($urandom);
			brightness <= CH_W'($urandom);
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		start <= 1'b1;
		hue <= h;
		saturation <= s;
		brightness <= v;
		stim_known <= known;
		stim_rgb <= rgb;
		do @(posedge clk); while (busy);
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (rgb_expected_q.size() != 0) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		hue = '0;
		saturation = '0;
		brightness = '0;
		stim_known = 1'b0;
		stim_rgb = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		foreach (pixel_rows[n])
			send_pixel(pixel_rows[n].h, pixel_rows[n].s, pixel_rows[n].v, pixel_rows[n].known,
				pixel_rows[n].rgb, 1'b1);
		drain();

		for (int i = 0; i < RANDOM_N; i++) begin
			if (i == RANDOM_N / 2)
				drain();
			send_pixel(pick_hue(), pick_level(), pick_level(), 1'b0, '0,
				(i < RANDOM_N - CALM_TAIL) && ((i / 150) % 3 != 2));
		end

		drain();
		repeat (PIPE_DEPTH + 4) @(posedge clk);
		if (rgb_expected_q.size() != 0) begin
			$error("%0d transactions never came out", rgb_expected_q.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- hsv_to_rgb_converter.f -----
src/hsv_pkg.sv
src/hsv_sector.sv
src/hsv_chan.sv
src/hsv_to_rgb_converter.sv
tb/sv/tb_hsv_to_rgb_converter.sv
